// File: hw/rtl/sga_pkg.sv
// shared types and constants for the global sequence alignment block
// no dependencies
`timescale 1ns / 1ps

package sga_pkg;

	localparam int SCORE_W = 12;

	typedef logic signed [SCORE_W-1:0] score_t;
	typedef logic [1:0] dir_t;
	typedef logic [7:0] char_t;

	localparam dir_t DIR_DIAG = 2'd0;
	localparam dir_t DIR_UP   = 2'd1;
	localparam dir_t DIR_LEFT = 2'd2;

	localparam char_t GAP_CH = 8'h2D;
	localparam char_t PAD_CH = 8'h5F;

endpackage

// File: hw/rtl/sga_ram.sv
// generic single write port ram with one registered read port
// no dependencies
`timescale 1ns / 1ps

module sga_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 128
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

// File: hw/rtl/sequence_global_alignment_top.sv
// global alignment top level: load, score fill, traceback and output packing
// depends on sga_pkg and sga_ram
`timescale 1ns / 1ps

// Usage:
// The input channel (in_valid, in_stall, packed_chars) takes the A words and
// then the B words, four bytes each, low byte first. Each word is written to
// the sequence memories one byte per cycle: it is taken in ST_LOAD, then its
// four bytes are written in ST_WRB before the next word can be taken.
// After the last word the block sweeps the SEQ_A_LEN+1 entries of row zero,
// then fills the matrix at one cell per cycle, with the ROW_RD and ROW_LD
// states between rows; the single score row memory and the direction memory
// write port set that rate. Each traceback step then reads the direction and
// sequence memories in ST_TB_RD and decides in ST_TB_EV, at most
// SEQ_A_LEN+SEQ_B_LEN steps, followed by the pad chars, one per cycle.
// Results leave on (out_valid, out_stall, a_chars, b_chars, last_word),
// ceil((SEQ_A_LEN+SEQ_B_LEN)/4) transactions, last_word on the final one.
// in_stall is high except while a word can be taken. A stalled output holds
// its result; traceback and padding pause when a finished word finds the
// output register still full. Reset returns to loading the first A word;
// memory contents are not cleared.

module sequence_global_alignment_top #(
	parameter int SEQ_A_LEN = 128,
	parameter int SEQ_B_LEN = 128
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [31:0] packed_chars,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [31:0] a_chars,
	output logic [31:0] b_chars,
	output logic        last_word
);

	import sga_pkg::*;

	localparam int TOTAL    = SEQ_A_LEN + SEQ_B_LEN;
	localparam int IN_WORDS = (TOTAL + 3) / 4;
	localparam int ROW_W    = SEQ_A_LEN + 1;
	localparam int DIR_D    = ROW_W * (SEQ_B_LEN + 1);
	localparam int AAW      = $clog2(SEQ_A_LEN);
	localparam int BAW      = $clog2(SEQ_B_LEN);
	localparam int AIW      = $clog2(SEQ_A_LEN + 1);
	localparam int BIW      = $clog2(SEQ_B_LEN + 1);
	localparam int DAW      = $clog2(DIR_D);
	localparam int PW       = $clog2(IN_WORDS * 4 + 1);
	localparam int RW       = $clog2(IN_WORDS + 1);

	typedef enum logic [8:0] {
		ST_LOAD   = 9'b000000001,
		ST_WRB    = 9'b000000010,
		ST_INIT   = 9'b000000100,
		ST_ROW_RD = 9'b000001000,
		ST_ROW_LD = 9'b000010000,
		ST_FILL   = 9'b000100000,
		ST_TB_RD  = 9'b001000000,
		ST_TB_EV  = 9'b010000000,
		ST_PAD    = 9'b100000000
	} state_t;

	state_t state_q;

	logic [31:0]    word_q;
	logic [PW-1:0]  pos_q;
	logic [AIW-1:0] init_q;
	logic [BIW-1:0] b_q;
	logic [DAW-1:0] base_q;
	logic [AIW-1:0] a_iss_q;
	logic           v_s1;
	logic [AIW-1:0] a_s1;
	char_t          bch_q;
	score_t         left_q, diag_q;
	logic [AIW-1:0] ta_q;
	logic [BIW-1:0] tb_q;
	logic [DAW-1:0] tbase_q;
	logic [1:0]     lane_q;
	logic [RW-1:0]  r_q;
	logic [23:0]    wa_q, wb_q;
	logic           out_valid_q;
	logic [31:0]    a_out_q, b_out_q;
	logic           last_q;

	// memory ports
	logic           sa_we, sb_we, sc_we, dr_we;
	logic [AAW-1:0] sa_waddr, sa_raddr;
	logic [BAW-1:0] sb_waddr, sb_raddr;
	logic [AIW-1:0] sc_waddr, sc_raddr;
	logic [DAW-1:0] dr_waddr, dr_raddr;
	char_t          byte_in, sa_rd, sb_rd;
	score_t         sc_wdata, sc_rd;
	dir_t           dr_wdata, dr_rd;

	logic [PW-1:0]  pos_b;
	score_t         c_diag, c_up, c_left, c_best;
	dir_t           c_dir;

	logic           can_push, emit, push;
	char_t          ca, cb;
	logic           step_diag, step_left, step_up;

	assign in_stall = (state_q != ST_LOAD);
	assign out_valid = out_valid_q;
	assign a_chars = a_out_q;
	assign b_chars = b_out_q;
	assign last_word = last_q;

	assign byte_in = word_q[8*pos_q[1:0] +: 8];
	assign pos_b = pos_q - PW'(SEQ_A_LEN);

	// cell evaluation
	always_comb begin
		c_diag = diag_q + ((sa_rd == bch_q) ? score_t'(1) : score_t'(-1));
		c_up   = sc_rd - score_t'(1);
		c_left = left_q - score_t'(1);
		c_best = c_diag;
		if (c_up > c_best) c_best = c_up;
		if (c_left > c_best) c_best = c_left;
		if (c_best == c_left) c_dir = DIR_LEFT;
		else if (c_best == c_up) c_dir = DIR_UP;
		else c_dir = DIR_DIAG;
	end

	// memory port muxing
	always_comb begin
		sa_we = 1'b0;
		sb_we = 1'b0;
		sa_waddr = pos_q[AAW-1:0];
		sb_waddr = pos_b[BAW-1:0];
		if (state_q == ST_WRB) begin
			if (pos_q < PW'(SEQ_A_LEN)) sa_we = 1'b1;
			else if (pos_q < PW'(TOTAL)) sb_we = 1'b1;
		end

		sc_we = 1'b0;
		sc_waddr = a_s1;
		sc_wdata = c_best;
		dr_we = 1'b0;
		dr_waddr = base_q + DAW'(a_s1);
		dr_wdata = c_dir;
		if (state_q == ST_INIT) begin
			sc_we = 1'b1;
			sc_waddr = init_q;
			sc_wdata = score_t'(0) - score_t'(init_q);
			dr_we = 1'b1;
			dr_waddr = DAW'(init_q);
			dr_wdata = DIR_LEFT;
		end else if (state_q == ST_ROW_LD) begin
			dr_we = 1'b1;
			dr_waddr = base_q + DAW'(ROW_W);
			dr_wdata = DIR_UP;
		end else if (v_s1) begin
			sc_we = 1'b1;
			dr_we = 1'b1;
		end

		sc_raddr = a_iss_q;
		sa_raddr = AAW'(a_iss_q - AIW'(1));
		sb_raddr = b_q[BAW-1:0];
		dr_raddr = tbase_q + DAW'(ta_q);
		if (state_q == ST_TB_RD || state_q == ST_TB_EV) begin
			sa_raddr = (ta_q == '0) ? '0 : AAW'(ta_q - AIW'(1));
			sb_raddr = (tb_q == '0) ? '0 : BAW'(tb_q - BIW'(1));
		end
	end

	// traceback step choice and char emission
	always_comb begin
		can_push = !out_valid_q || !out_stall;
		step_diag = (dr_rd == DIR_DIAG) && (ta_q != '0) && (tb_q != '0);
		step_left = !step_diag && (dr_rd == DIR_LEFT) && (ta_q != '0);
		step_up = !step_diag && !step_left && (tb_q != '0);
		ca = PAD_CH;
		cb = PAD_CH;
		emit = 1'b0;
		if (state_q == ST_TB_EV) begin
			emit = (lane_q != 2'd3) || can_push;
			priority if (step_diag) begin
				ca = sa_rd;
				cb = sb_rd;
			end else if (step_left) begin
				ca = sa_rd;
				cb = GAP_CH;
			end else if (step_up) begin
				ca = GAP_CH;
				cb = sb_rd;
			end else begin
				ca = sa_rd;
				cb = GAP_CH;
			end
		end else if (state_q == ST_PAD) begin
			emit = (r_q != RW'(IN_WORDS)) && ((lane_q != 2'd3) || can_push);
		end
		push = emit && (lane_q == 2'd3);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_LOAD;
			pos_q <= '0;
			init_q <= '0;
			b_q <= '0;
			base_q <= '0;
			a_iss_q <= '0;
			v_s1 <= 1'b0;
			ta_q <= '0;
			tb_q <= '0;
			tbase_q <= '0;
			lane_q <= '0;
			r_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			v_s1 <= (state_q == ST_FILL);
			unique case (state_q)
				ST_LOAD: begin
					if (in_valid) state_q <= ST_WRB;
				end
				ST_WRB: begin
					if (pos_q[1:0] == 2'd3 && pos_q + PW'(1) == PW'(IN_WORDS * 4)) begin
						pos_q <= '0;
						init_q <= '0;
						state_q <= ST_INIT;
					end else begin
						pos_q <= pos_q + PW'(1);
						if (pos_q[1:0] == 2'd3) state_q <= ST_LOAD;
					end
				end
				ST_INIT: begin
					init_q <= init_q + AIW'(1);
					if (init_q == AIW'(SEQ_A_LEN)) begin
						b_q <= '0;
						base_q <= '0;
						state_q <= ST_ROW_RD;
					end
				end
				ST_ROW_RD: begin
					// last cell of the previous row retires here
					if (b_q == BIW'(SEQ_B_LEN)) begin
						ta_q <= AIW'(SEQ_A_LEN);
						tb_q <= b_q;
						tbase_q <= base_q;
						lane_q <= '0;
						r_q <= '0;
						state_q <= ST_TB_RD;
					end else begin
						state_q <= ST_ROW_LD;
					end
				end
				ST_ROW_LD: begin
					b_q <= b_q + BIW'(1);
					base_q <= base_q + DAW'(ROW_W);
					a_iss_q <= AIW'(1);
					state_q <= ST_FILL;
				end
				ST_FILL: begin
					a_iss_q <= a_iss_q + AIW'(1);
					if (a_iss_q == AIW'(SEQ_A_LEN)) state_q <= ST_ROW_RD;
				end
				ST_TB_RD: begin
					if (ta_q == '0 && tb_q == '0) state_q <= ST_PAD;
					else state_q <= ST_TB_EV;
				end
				ST_TB_EV: begin
					if (emit) begin
						state_q <= ST_TB_RD;
						if (step_diag) begin
							ta_q <= ta_q - AIW'(1);
							tb_q <= tb_q - BIW'(1);
							tbase_q <= tbase_q - DAW'(ROW_W);
						end else if (step_up) begin
							tb_q <= tb_q - BIW'(1);
							tbase_q <= tbase_q - DAW'(ROW_W);
						end else begin
							ta_q <= ta_q - AIW'(1);
						end
					end
				end
				ST_PAD: begin
					if (r_q == RW'(IN_WORDS)) state_q <= ST_LOAD;
				end
				default: state_q <= ST_LOAD;
			endcase

			if (emit) begin
				lane_q <= lane_q + 2'd1;
				if (push) r_q <= r_q + RW'(1);
			end

			if (push) out_valid_q <= 1'b1;
			else if (!out_stall) out_valid_q <= 1'b0;
		end
	end

	// datapath registers, no reset needed
	always_ff @(posedge clk) begin
		if (state_q == ST_LOAD && in_valid) word_q <= packed_chars;
		a_s1 <= a_iss_q;
		if (state_q == ST_ROW_LD) begin
			bch_q <= sb_rd;
			left_q <= score_t'(0) - score_t'(b_q) - score_t'(1);
			diag_q <= score_t'(0) - score_t'(b_q);
		end else if (v_s1) begin
			left_q <= c_best;
			diag_q <= sc_rd;
		end
		if (emit && lane_q != 2'd3) begin
			wa_q[8*lane_q +: 8] <= ca;
			wb_q[8*lane_q +: 8] <= cb;
		end
		if (push) begin
			a_out_q <= {ca, wa_q};
			b_out_q <= {cb, wb_q};
			last_q <= (r_q == RW'(IN_WORDS - 1));
		end
	end

	sga_ram #(.WIDTH(8), .DEPTH(SEQ_A_LEN)) u_seq_a (
		.clk(clk), .we(sa_we), .waddr(sa_waddr), .wdata(byte_in),
		.raddr(sa_raddr), .rdata(sa_rd)
	);

	sga_ram #(.WIDTH(8), .DEPTH(SEQ_B_LEN)) u_seq_b (
		.clk(clk), .we(sb_we), .waddr(sb_waddr), .wdata(byte_in),
		.raddr(sb_raddr), .rdata(sb_rd)
	);

	sga_ram #(.WIDTH(SCORE_W), .DEPTH(ROW_W)) u_score_row (
		.clk(clk), .we(sc_we), .waddr(sc_waddr), .wdata(sc_wdata),
		.raddr(sc_raddr), .rdata(sc_rd)
	);

	sga_ram #(.WIDTH(2), .DEPTH(DIR_D)) u_dir (
		.clk(clk), .we(dr_we), .waddr(dr_waddr), .wdata(dr_wdata),
		.raddr(dr_raddr), .rdata(dr_rd)
	);

	a_push_room: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> (!out_valid_q || !out_stall))
		else $error("result pushed over a stalled output");

	a_s1_in_fill: assert property (@(posedge clk) disable iff (!arst_n)
		v_s1 |-> (state_q == ST_FILL || state_q == ST_ROW_RD))
		else $error("cell in flight outside fill");

	a_word_bound: assert property (@(posedge clk) disable iff (!arst_n)
		r_q <= RW'(IN_WORDS))
		else $error("too many result words");

	a_last_done: assert property (@(posedge clk) disable iff (!arst_n)
		(push && r_q == RW'(IN_WORDS - 1)) |=> (r_q == RW'(IN_WORDS)))
		else $error("word count off after final result");

	a_dir_range: assert property (@(posedge clk) disable iff (!arst_n)
		dr_we |-> (dr_waddr < DAW'(DIR_D)))
		else $error("direction write beyond matrix");

endmodule

// File: dv/sga_checker.sv
// monitor, alignment predictor and result checker for sequence_global_alignment_top
// depends on sga_pkg for direction codes and gap/pad characters
`timescale 1ns / 1ps

module sga_checker #(
	parameter int SEQ_A_LEN = 128,
	parameter int SEQ_B_LEN = 128
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	input  logic        in_stall,
	input  logic [31:0] packed_chars,
	input  logic        out_valid,
	input  logic        out_stall,
	input  logic [31:0] a_chars,
	input  logic [31:0] b_chars,
	input  logic        last_word,
	output int          errors,
	output int          pending,
	output int          alignments_done
);
	import sga_pkg::*;

	localparam int TOTAL = SEQ_A_LEN + SEQ_B_LEN;
	localparam int WORDS = (TOTAL + 3) / 4;

	typedef struct packed {
		logic [31:0] a;
		logic [31:0] b;
		logic        last;
	} pair_word_t;

	pair_word_t aligned_q[$];
	char_t      seq_a[SEQ_A_LEN];
	char_t      seq_b[SEQ_B_LEN];
	dir_t       trace_dir[SEQ_B_LEN+1][SEQ_A_LEN+1];
	int         words_loaded;

	// score fill with left/up/diag tie order, then traceback from the corner
	task automatic align_and_queue();
		int prev_row[SEQ_A_LEN+1];
		int cur_row[SEQ_A_LEN+1];
		char_t out_a[TOTAL+4];
		char_t out_b[TOTAL+4];
		int ia, ib, k, diag, up, left, best;
		pair_word_t w;
		for (ia = 0; ia <= SEQ_A_LEN; ia++) begin
			prev_row[ia] = -ia;
			trace_dir[0][ia] = DIR_LEFT;
		end
		for (ib = 1; ib <= SEQ_B_LEN; ib++) begin
			cur_row[0] = -ib;
			trace_dir[ib][0] = DIR_UP;
			for (ia = 1; ia <= SEQ_A_LEN; ia++) begin
				diag = prev_row[ia-1] + ((seq_a[ia-1] == seq_b[ib-1]) ? 1 : -1);
				up = prev_row[ia] - 1;
				left = cur_row[ia-1] - 1;
				best = diag;
				if (up > best) best = up;
				if (left > best) best = left;
				if (best == left) trace_dir[ib][ia] = DIR_LEFT;
				else if (best == up) trace_dir[ib][ia] = DIR_UP;
				else trace_dir[ib][ia] = DIR_DIAG;
				cur_row[ia] = best;
			end
			prev_row = cur_row;
		end
		for (k = 0; k < TOTAL + 4; k++) begin
			out_a[k] = PAD_CH;
			out_b[k] = PAD_CH;
		end
		ia = SEQ_A_LEN;
		ib = SEQ_B_LEN;
		k = 0;
		while ((ia > 0 || ib > 0) && k < TOTAL) begin
			if (trace_dir[ib][ia] == DIR_DIAG && ia > 0 && ib > 0) begin
				out_a[k] = seq_a[ia-1];
				out_b[k] = seq_b[ib-1];
				ia--;
				ib--;
			end else if (trace_dir[ib][ia] == DIR_LEFT && ia > 0) begin
				out_a[k] = seq_a[ia-1];
				out_b[k] = GAP_CH;
				ia--;
			end else if (ib > 0) begin
				out_a[k] = GAP_CH;
				out_b[k] = seq_b[ib-1];
				ib--;
			end else begin
				out_a[k] = seq_a[ia-1];
				out_b[k] = GAP_CH;
				ia--;
			end
			k++;
		end
		for (k = 0; k < WORDS; k++) begin
			w.a = {out_a[4*k+3], out_a[4*k+2], out_a[4*k+1], out_a[4*k]};
			w.b = {out_b[4*k+3], out_b[4*k+2], out_b[4*k+1], out_b[4*k]};
			w.last = (k == WORDS - 1);
			aligned_q.push_back(w);
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			words_loaded <= 0;
			errors = 0;
			alignments_done = 0;
			pending = 0;
		end else begin
			if (in_valid && !in_stall) begin
				for (int j = 0; j < 4; j++) begin
					int p;
					p = words_loaded * 4 + j;
					if (p < SEQ_A_LEN) seq_a[p] = packed_chars[8*j +: 8];
					else if (p < TOTAL) seq_b[p - SEQ_A_LEN] = packed_chars[8*j +: 8];
				end
				if (words_loaded == WORDS - 1) begin
					words_loaded <= 0;
					align_and_queue();
				end else begin
					words_loaded <= words_loaded + 1;
				end
			end
			if (out_valid && !out_stall) begin
				if (aligned_q.size() == 0) begin
					$display("%0t: unexpected result a=%h b=%h last=%b",
						$time, a_chars, b_chars, last_word);
					errors++;
				end else begin
					pair_word_t e;
					e = aligned_q.pop_front();
					if (a_chars !== e.a) begin
						$display("%0t: a_chars expected %h actual %h", $time, e.a, a_chars);
						errors++;
					end
					if (b_chars !== e.b) begin
						$display("%0t: b_chars expected %h actual %h", $time, e.b, b_chars);
						errors++;
					end
					if (last_word !== e.last) begin
						$display("%0t: last_word expected %b actual %b",
							$time, e.last, last_word);
						errors++;
					end
					if (e.last) alignments_done++;
				end
			end
			pending = aligned_q.size();
		end
	end

endmodule

// File: dv/sequence_global_alignment_top_tb.sv
// testbench top for sequence_global_alignment_top: clock, reset, stimulus, verdict
// depends on sga_pkg, the block and sga_checker
`timescale 1ns / 1ps

module sequence_global_alignment_top_tb;
	import sga_pkg::*;

	localparam int LEN_A = 128;
	localparam int LEN_B = 128;
	localparam int TOTAL = LEN_A + LEN_B;
	localparam int WORDS = (TOTAL + 3) / 4;
	localparam int CYCLE_LIMIT = 1000000;
	localparam int HOLDOFF_CYCLES = 30000;

	logic        clk = 0;
	logic        arst_n = 0;
	logic        in_valid = 0;
	logic        in_stall;
	logic [31:0] packed_chars = '0;
	logic        out_valid;
	logic        out_stall = 0;
	logic [31:0] a_chars;
	logic [31:0] b_chars;
	logic        last_word;

	int errors, pending, alignments_done;
	int send_idle_pct = 0;
	int recv_stall_pct = 0;
	int holdoff_reqs = 0;
	int holdoff_seen = 0;
	int holdoff_left = 0;
	int cycles = 0;
	int words_sent = 0;
	char_t seq_buf[TOTAL];

	always #5 clk = ~clk;

	sequence_global_alignment_top #(.SEQ_A_LEN(LEN_A), .SEQ_B_LEN(LEN_B)) dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall), .packed_chars(packed_chars),
		.out_valid(out_valid), .out_stall(out_stall),
		.a_chars(a_chars), .b_chars(b_chars), .last_word(last_word)
	);

	sga_checker #(.SEQ_A_LEN(LEN_A), .SEQ_B_LEN(LEN_B)) checker_i (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall), .packed_chars(packed_chars),
		.out_valid(out_valid), .out_stall(out_stall),
		.a_chars(a_chars), .b_chars(b_chars), .last_word(last_word),
		.errors(errors), .pending(pending), .alignments_done(alignments_done)
	);

	// receiver: long hold-off when requested, otherwise random stalls
	always @(posedge clk) begin
		if (holdoff_reqs != holdoff_seen) begin
			holdoff_seen <= holdoff_reqs;
			holdoff_left <= HOLDOFF_CYCLES;
			out_stall <= 1;
		end else if (holdoff_left > 0) begin
			holdoff_left <= holdoff_left - 1;
			out_stall <= 1;
		end else begin
			out_stall <= ($urandom_range(99) < recv_stall_pct);
		end
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d results outstanding", cycles, pending);
			$display("FAIL");
			$finish;
		end
	end

	// sends seq_buf as one alignment, low byte first
	task automatic send_alignment();
		logic [31:0] w;
		for (int i = 0; i < WORDS; i++) begin
			for (int j = 0; j < 4; j++)
				w[8*j +: 8] = (4*i + j < TOTAL) ? seq_buf[4*i + j] : char_t'($urandom);
			while ($urandom_range(99) < send_idle_pct) begin
				in_valid <= 0;
				packed_chars <= $urandom;
				@(posedge clk);
			end
			in_valid <= 1;
			packed_chars <= w;
			do @(posedge clk); while (in_stall);
			words_sent++;
		end
		in_valid <= 0;
	endtask

	// mostly a small alphabet with B a mutated, shifted copy of A
	task automatic make_related_pair();
		int shift;
		shift = $urandom_range(6);
		for (int i = 0; i < LEN_A; i++)
			seq_buf[i] = ($urandom_range(9) == 0) ? char_t'($urandom) :
				char_t'("ACGT" >> (8 * $urandom_range(3)));
		for (int i = 0; i < LEN_B; i++)
			seq_buf[LEN_A + i] = ($urandom_range(5) == 0) ? char_t'($urandom) :
				seq_buf[(i + shift) % LEN_A];
	endtask

	// one edge first so the checker has queued the last transaction's results
	task automatic wait_drained();
		@(posedge clk);
		while (pending != 0) @(posedge clk);
	endtask

	initial begin
		repeat (7) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		// directed: extreme bytes, gap and pad characters, offset copy forcing gaps
		for (int i = 0; i < LEN_A; i++)
			seq_buf[i] = (i == 0) ? 8'h00 : (i == 1) ? 8'hFF : (i == 2) ? GAP_CH :
				(i == 3) ? PAD_CH : char_t'(i * 2 + 1);
		for (int i = 0; i < LEN_B; i++)
			seq_buf[LEN_A + i] = (i < 4) ? seq_buf[i] : (i % 17 == 0) ? 8'hAA :
				seq_buf[(i + 2) % LEN_A];
		send_alignment();
		// sender pauses until every result is back
		wait_drained();

		// idle sender, then its results drain behind a long hold-off and heavy stalls
		send_idle_pct = 79;
		make_related_pair();
		send_alignment();
		recv_stall_pct = 79;
		holdoff_reqs++;

		// next alignment is offered while the block still holds the previous one
		send_idle_pct = 13;
		for (int i = 0; i < TOTAL; i++) seq_buf[i] = char_t'($urandom);
		send_alignment();
		recv_stall_pct = 13;
		wait_drained();
		repeat (200) @(posedge clk);

		$display("sent %0d words, %0d alignments checked across idle, stall and hold-off phases",
			words_sent, alignments_done);
		if (errors == 0) begin
			$display("PASS");
		end else begin
			$display("%0d mismatches", errors);
			$display("FAIL");
		end
		$finish;
	end

endmodule
